// File: hw/rtl/assert_macros.svh
// Shared assertion macros for the checker module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold in the cycle after the condition, reset included.
`define CHK_NEXT(label, clk, cond, prop) \
    label: assert property (@(posedge clk) (cond) |=> (prop)) \
        else $error("check failed");

// As above, but not checked while reset is applied.
`define CHK_NEXT_RST(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond) |=> (prop)) \
        else $error("check failed");

`endif

// File: hw/rtl/idw_pkg.sv
package idw_pkg;

    localparam logic [1:0] OP_WR_VAL   = 2'd0;
    localparam logic [1:0] OP_WR_COORD = 2'd1;
    localparam logic [1:0] OP_QUERY    = 2'd2;

    localparam logic REG_STEP_SIZE = 1'b0;
    localparam logic REG_ORIGIN    = 1'b1;

    localparam logic [30:0] STEP_RESET   = 31'd65536;
    localparam logic [31:0] ORIGIN_RESET = 32'd0;

    localparam int QD = 4;
    localparam int PW = $clog2(QD);

    typedef enum logic [1:0] {
        K_NONE,
        K_WR_VAL,
        K_WR_COORD,
        K_QUERY
    } t_kind;

    typedef struct packed {
        t_kind       kind;
        logic [5:0]  row;
        logic [5:0]  col;
        logic [31:0] data;
        logic [31:0] r;
        logic [31:0] r0;
    } t_item;

endpackage

// File: hw/rtl/inverse_distance_grid_interpolator.sv
// Throughput: one item per cycle while the output is not stalled; the square roots
// and the cell index, weight and final dividers are fully pipelined, one bit per
// stage, and the table is read once per corner copy.
// Writes take effect in order with queries and give no result item.
// Reset is synchronous: the queue and all pipeline valid flags clear, and the
// configuration returns to a step of 1.0 and an origin of 0; tables are not cleared.
module inverse_distance_grid_interpolator import idw_pkg::*; #(
    parameter int GRID = 64
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // row_index, col_index, entry_data, r_coord, r0_coord, zero padding
    input  logic [111:0] s_axis_tdata,
    // operation
    input  logic [1:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // interp_value
    output logic [31:0]  m_axis_tdata,
    // index_clamped
    output logic         m_axis_tuser,
    input  logic         i_cfg_we,
    input  logic         i_cfg_index,
    input  logic [31:0]  i_cfg_data
);

    logic [30:0] r_step_size;
    logic [31:0] r_origin;
    logic        q_valid;
    t_item       q_item;
    logic        q_pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step_size <= STEP_RESET;
            r_origin <= ORIGIN_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_STEP_SIZE: r_step_size <= i_cfg_data[30:0];
                REG_ORIGIN:    r_origin <= i_cfg_data;
                default:       r_origin <= r_origin;
            endcase
        end
    end

    idw_front #(.GRID(GRID)) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(s_axis_tvalid), .o_ready(s_axis_tready),
        .i_op(s_axis_tuser), .i_row(s_axis_tdata[5:0]), .i_col(s_axis_tdata[11:6]),
        .i_data(s_axis_tdata[43:12]), .i_r(s_axis_tdata[75:44]),
        .i_r0(s_axis_tdata[107:76]),
        .o_valid(q_valid), .o_item(q_item), .i_pop(q_pop)
    );

    idw_back #(.GRID(GRID)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_step_size(r_step_size), .i_origin(r_origin),
        .i_q_valid(q_valid), .i_q_item(q_item), .o_q_pop(q_pop),
        .o_valid(m_axis_tvalid), .i_ready(m_axis_tready),
        .o_value(m_axis_tdata), .o_clamped(m_axis_tuser)
    );

endmodule

// File: hw/rtl/idw_ram.sv
module idw_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: hw/rtl/idw_div.sv
module idw_div #(
    parameter int NW = 32,
    parameter int DW = 31,
    parameter int QW = 6,
    parameter int SW = 1
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    input  logic [SW-1:0] i_side,
    output logic [QW-1:0] o_q,
    output logic [SW-1:0] o_side
);

    // The quotient is known to fit in QW bits; one quotient bit per stage.
    localparam int CW = (NW > DW + QW) ? NW : DW + QW;

    logic [CW-1:0] r_rem  [QW];
    logic [DW-1:0] r_den  [QW];
    logic [QW-1:0] r_q    [QW];
    logic [SW-1:0] r_side [QW];
    logic [CW-1:0] n_rem  [QW];
    logic [DW-1:0] n_den  [QW];
    logic [QW-1:0] n_q    [QW];
    logic [SW-1:0] n_side [QW];

    always_comb begin
        logic [CW-1:0] rem;
        logic [DW-1:0] den;
        logic [QW-1:0] q;
        logic [CW-1:0] trial;
        for (int k = 0; k < QW; k++) begin
            if (k == 0) begin
                rem = CW'(i_num);
                den = i_den;
                q = '0;
                n_side[k] = i_side;
            end else begin
                rem = r_rem[k-1];
                den = r_den[k-1];
                q = r_q[k-1];
                n_side[k] = r_side[k-1];
            end
            trial = CW'(den) << (QW - 1 - k);
            n_den[k] = den;
            if (rem >= trial) begin
                n_rem[k] = rem - trial;
                n_q[k] = q | (QW'(1) << (QW - 1 - k));
            end else begin
                n_rem[k] = rem;
                n_q[k] = q;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < QW; k++) begin
                r_side[k] <= '0;
            end
        end else if (i_en) begin
            r_rem <= n_rem;
            r_den <= n_den;
            r_q <= n_q;
            r_side <= n_side;
        end
    end

    assign o_q = r_q[QW-1];
    assign o_side = r_side[QW-1];

endmodule

// File: hw/rtl/idw_sqrt.sv
module idw_sqrt #(
    parameter int SW = 32
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic [63:0]   i_x,
    input  logic [SW-1:0] i_side,
    output logic [31:0]   o_root,
    output logic [SW-1:0] o_side
);

    // Floor square root, one result bit per stage.
    localparam int NS = 32;

    logic [63:0]   r_x    [NS];
    logic [63:0]   r_res  [NS];
    logic [SW-1:0] r_side [NS];
    logic [63:0]   n_x    [NS];
    logic [63:0]   n_res  [NS];
    logic [SW-1:0] n_side [NS];

    always_comb begin
        logic [63:0] x;
        logic [63:0] res;
        logic [63:0] bitv;
        for (int k = 0; k < NS; k++) begin
            if (k == 0) begin
                x = i_x;
                res = '0;
                n_side[k] = i_side;
            end else begin
                x = r_x[k-1];
                res = r_res[k-1];
                n_side[k] = r_side[k-1];
            end
            bitv = 64'd1 << (62 - 2 * k);
            if (x >= res + bitv) begin
                n_x[k] = x - (res + bitv);
                n_res[k] = (res >> 1) + bitv;
            end else begin
                n_x[k] = x;
                n_res[k] = res >> 1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NS; k++) begin
                r_side[k] <= '0;
            end
        end else if (i_en) begin
            r_x <= n_x;
            r_res <= n_res;
            r_side <= n_side;
        end
    end

    assign o_root = r_res[NS-1][31:0];
    assign o_side = r_side[NS-1];

endmodule

// File: hw/rtl/idw_front.sv
module idw_front import idw_pkg::*; #(
    parameter int GRID = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_op,
    input  logic [5:0]  i_row,
    input  logic [5:0]  i_col,
    input  logic [31:0] i_data,
    input  logic [31:0] i_r,
    input  logic [31:0] i_r0,
    output logic        o_valid,
    output t_item       o_item,
    input  logic        i_pop
);

    t_item         r_mem [QD];
    logic [PW-1:0] r_wp;
    logic [PW-1:0] r_rp;
    logic [PW:0]   r_cnt;
    t_kind         kind;
    logic          push;

    always_comb begin
        unique case (i_op)
            OP_WR_VAL: begin
                kind = (int'(i_row) < GRID && int'(i_col) < GRID) ? K_WR_VAL : K_NONE;
            end
            OP_WR_COORD: begin
                kind = (int'(i_col) < GRID) ? K_WR_COORD : K_NONE;
            end
            OP_QUERY: begin
                kind = K_QUERY;
            end
            default: begin
                kind = K_NONE;
            end
        endcase
    end

    assign o_ready = r_cnt != (PW + 1)'(QD);
    assign push = i_valid && o_ready && kind != K_NONE;
    assign o_valid = r_cnt != '0;
    assign o_item = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= '{kind: kind, row: i_row, col: i_col, data: i_data,
                             r: i_r, r0: i_r0};
        end
        if (!i_rst_n) begin
            r_wp <= '0;
            r_rp <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wp <= r_wp + PW'(1);
            end
            if (i_pop) begin
                r_rp <= r_rp + PW'(1);
            end
            r_cnt <= r_cnt + (PW + 1)'(push) - (PW + 1)'(i_pop);
        end
    end

endmodule

// File: hw/rtl/idw_back.sv
module idw_back import idw_pkg::*; #(
    parameter int GRID = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic [30:0] i_step_size,
    input  logic [31:0] i_origin,
    input  logic        i_q_valid,
    input  t_item       i_q_item,
    output logic        o_q_pop,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [31:0] o_value,
    output logic        o_clamped
);

    localparam int IW = $clog2(GRID);
    localparam int AW = $clog2(GRID * GRID);
    localparam int LW = 32 + IW;

    typedef struct packed {
        logic  valid;
        t_item item;
        logic  neg_r;
        logic  over_r;
    } t_s1;

    typedef struct packed {
        logic valid;
        logic query;
        logic diag;
        logic clamped;
    } t_ctl;

    typedef struct packed {
        t_ctl        ctl;
        logic        byp;
        logic [31:0] bypv;
    } t_bs;

    typedef struct packed {
        t_bs         b;
        logic [31:0] v;
    } t_ws;

    typedef struct packed {
        t_bs  b;
        logic neg;
    } t_fs;

    function automatic logic [30:0] sat_abs(input logic [31:0] a, input logic [31:0] b);
        logic [32:0] d;
        logic [32:0] m;
        d = {a[31], a} - {b[31], b};
        m = d[32] ? (33'd0 - d) : d;
        return (m > 33'h07FFFFFFF) ? 31'h7FFFFFFF : m[30:0];
    endfunction

    function automatic logic [AW-1:0] taddr(input logic [AW-1:0] row, input logic [AW-1:0] col);
        return row * AW'(GRID) + col;
    endfunction

    logic en;
    logic r_out_valid;
    logic [31:0] r_out_value;
    logic r_out_clamped;

    assign en = !r_out_valid || i_ready;
    assign o_q_pop = en && i_q_valid;

    // Step and upper limit follow the configuration registers.
    logic [30:0]   r_step;
    logic [LW-1:0] r_lim;

    always_ff @(posedge i_clk) begin
        r_step <= (i_step_size == '0) ? 31'd1 : i_step_size;
        r_lim <= LW'(r_step) * LW'(GRID - 1);
    end

    // Cell index front end.
    logic [32:0] dc;
    logic [32:0] dr;
    t_s1         r_s1;
    logic [31:0] r_dc;
    logic [31:0] r_dr;
    logic        r_negc;
    logic        r_overc;

    assign dc = {i_q_item.r[31], i_q_item.r} - {i_origin[31], i_origin};
    assign dr = {i_q_item.r0[31], i_q_item.r0} - {i_origin[31], i_origin};

    logic [IW-1:0]          qc;
    logic [IW-1:0]          qr;
    logic [1:0]             c2;
    logic [$bits(t_s1)-1:0] s2_raw;
    t_s1                    s2;

    idw_div #(.NW(32), .DW(31), .QW(IW), .SW(2)) u_div_c (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en),
        .i_num(r_dc), .i_den(r_step), .i_side({r_negc, r_overc}),
        .o_q(qc), .o_side(c2)
    );

    idw_div #(.NW(32), .DW(31), .QW(IW), .SW($bits(t_s1))) u_div_r (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en),
        .i_num(r_dr), .i_den(r_step), .i_side(r_s1),
        .o_q(qr), .o_side(s2_raw)
    );

    assign s2 = t_s1'(s2_raw);

    logic [IW-1:0] i0;
    logic [IW-1:0] i1;
    logic [IW-1:0] ic;
    logic [IW-1:0] ic1;
    logic [AW-1:0] t_ra [4];
    logic [IW-1:0] c_ra [4];
    logic          we_val;
    logic          we_crd;

    assign i0 = s2.neg_r ? '0 : (s2.over_r ? IW'(GRID - 2) : qr);
    assign ic = c2[1] ? '0 : (c2[0] ? IW'(GRID - 2) : qc);
    assign i1 = i0 + IW'(1);
    assign ic1 = ic + IW'(1);

    assign t_ra[0] = taddr(AW'(i0), AW'(ic));
    assign t_ra[1] = taddr(AW'(i0), AW'(ic1));
    assign t_ra[2] = taddr(AW'(i1), AW'(ic1));
    assign t_ra[3] = taddr(AW'(i1), AW'(ic));
    assign c_ra[0] = i0;
    assign c_ra[1] = i1;
    assign c_ra[2] = ic;
    assign c_ra[3] = ic1;

    assign we_val = en && s2.valid && s2.item.kind == K_WR_VAL;
    assign we_crd = en && s2.valid && s2.item.kind == K_WR_COORD;

    logic [31:0] tval [4];
    logic [31:0] cval [4];

    for (genvar g = 0; g < 4; g++) begin : g_mem
        idw_ram #(.WIDTH(32), .DEPTH(GRID * GRID)) u_tab (
            .i_clk(i_clk), .i_we(we_val),
            .i_waddr(taddr(AW'(s2.item.row), AW'(s2.item.col))),
            .i_wdata(s2.item.data), .i_re(en), .i_raddr(t_ra[g]), .o_rdata(tval[g])
        );
        idw_ram #(.WIDTH(32), .DEPTH(GRID)) u_crd (
            .i_clk(i_clk), .i_we(we_crd), .i_waddr(IW'(s2.item.col)),
            .i_wdata(s2.item.data), .i_re(en), .i_raddr(c_ra[g]), .o_rdata(cval[g])
        );
    end

    t_ctl        r_c3;
    logic [31:0] r_r3;
    logic [31:0] r_r03;

    t_ctl        r_c4;
    logic [30:0] r_dy [2];
    logic [30:0] r_dx [2];
    logic [31:0] r_v4 [4];

    t_ctl        r_c5;
    logic [61:0] r_sy [2];
    logic [61:0] r_sx [2];
    logic [31:0] r_v5 [4];

    t_ctl        r_c6;
    logic [62:0] r_sum [4];
    logic [31:0] r_v6 [4];

    logic [31:0]               dst [4];
    logic [31:0]               sq_val [4];
    t_ctl                      sq_ctl;
    logic [$bits(t_ctl)+31:0]  sq0_side;

    idw_sqrt #(.SW($bits(t_ctl) + 32)) u_sqrt0 (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en),
        .i_x(64'(r_sum[0])), .i_side({r_c6, r_v6[0]}),
        .o_root(dst[0]), .o_side(sq0_side)
    );

    assign sq_ctl = t_ctl'(sq0_side[$bits(t_ctl)+31:32]);
    assign sq_val[0] = sq0_side[31:0];

    for (genvar g = 1; g < 4; g++) begin : g_sqrt
        idw_sqrt #(.SW(32)) u_sqrt (
            .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en),
            .i_x(64'(r_sum[g])), .i_side(r_v6[g]),
            .o_root(dst[g]), .o_side(sq_val[g])
        );
    end

    logic        byp;
    logic [31:0] bypv;
    logic [31:0] m01;
    logic [31:0] m23;

    // The diagonal wins; otherwise the first corner at zero distance.
    always_comb begin
        byp = sq_ctl.diag;
        bypv = sq_val[0];
        if (!sq_ctl.diag) begin
            for (int k = 3; k >= 0; k--) begin
                if (dst[k] == '0) begin
                    byp = 1'b1;
                    bypv = sq_val[k];
                end
            end
        end
    end

    assign m01 = (dst[1] < dst[0]) ? dst[1] : dst[0];
    assign m23 = (dst[3] < dst[2]) ? dst[3] : dst[2];

    t_bs         r_b7;
    logic [31:0] r_dmin7;
    logic [31:0] r_d7 [4];
    logic [31:0] r_v7 [4];

    logic [16:0]            w [4];
    logic [31:0]            wv [4];
    logic [$bits(t_ws)-1:0] w0_side;
    t_ws                    ws0;

    idw_div #(.NW(48), .DW(32), .QW(17), .SW($bits(t_ws))) u_wdiv0 (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en),
        .i_num({r_dmin7, 16'd0}), .i_den(r_d7[0]), .i_side({r_b7, r_v7[0]}),
        .o_q(w[0]), .o_side(w0_side)
    );

    assign ws0 = t_ws'(w0_side);
    assign wv[0] = ws0.v;

    for (genvar g = 1; g < 4; g++) begin : g_wdiv
        idw_div #(.NW(48), .DW(32), .QW(17), .SW(32)) u_wdiv (
            .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en),
            .i_num({r_dmin7, 16'd0}), .i_den(r_d7[g]), .i_side(r_v7[g]),
            .o_q(w[g]), .o_side(wv[g])
        );
    end

    t_bs                r_b8;
    logic signed [49:0] r_p8 [4];
    logic [16:0]        r_w8 [4];

    t_bs                r_b9;
    logic signed [51:0] r_num9;
    logic [18:0]        r_den9;

    t_bs                r_b10;
    logic               r_neg10;
    logic [51:0]        r_mag10;
    logic [18:0]        r_den10;

    t_bs                r_b11;
    logic               r_neg11;
    logic [51:0]        r_n11;
    logic [18:0]        r_den11;

    logic [31:0]            fq;
    logic [$bits(t_fs)-1:0] fs_raw;
    t_fs                    fs;
    logic [31:0]            res;

    idw_div #(.NW(52), .DW(19), .QW(32), .SW($bits(t_fs))) u_fdiv (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en),
        .i_num(r_n11), .i_den(r_den11), .i_side({r_b11, r_neg11}),
        .o_q(fq), .o_side(fs_raw)
    );

    assign fs = t_fs'(fs_raw);
    assign res = fs.b.byp ? fs.b.bypv : (fs.neg ? 32'd0 - fq : fq);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1 <= '0;
            r_c3 <= '0;
            r_c4 <= '0;
            r_c5 <= '0;
            r_c6 <= '0;
            r_b7 <= '0;
            r_b8 <= '0;
            r_b9 <= '0;
            r_b10 <= '0;
            r_b11 <= '0;
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_s1 <= '{valid: i_q_valid, item: i_q_item, neg_r: dr[32],
                      over_r: !dr[32] && LW'(dr[31:0]) >= r_lim};
            r_dr <= dr[31:0];
            r_dc <= dc[31:0];
            r_negc <= dc[32];
            r_overc <= !dc[32] && LW'(dc[31:0]) >= r_lim;

            r_c3 <= '{valid: s2.valid, query: s2.item.kind == K_QUERY, diag: i0 == ic,
                      clamped: c2[0] || s2.over_r};
            r_r3 <= s2.item.r;
            r_r03 <= s2.item.r0;

            r_c4 <= r_c3;
            r_dy[0] <= sat_abs(cval[0], r_r03);
            r_dy[1] <= sat_abs(cval[1], r_r03);
            r_dx[0] <= sat_abs(cval[2], r_r3);
            r_dx[1] <= sat_abs(cval[3], r_r3);
            r_v4 <= tval;

            r_c5 <= r_c4;
            for (int j = 0; j < 2; j++) begin
                r_sy[j] <= 62'(r_dy[j]) * 62'(r_dy[j]);
                r_sx[j] <= 62'(r_dx[j]) * 62'(r_dx[j]);
            end
            r_v5 <= r_v4;

            r_c6 <= r_c5;
            r_sum[0] <= 63'(r_sy[0]) + 63'(r_sx[0]);
            r_sum[1] <= 63'(r_sy[0]) + 63'(r_sx[1]);
            r_sum[2] <= 63'(r_sy[1]) + 63'(r_sx[1]);
            r_sum[3] <= 63'(r_sy[1]) + 63'(r_sx[0]);
            r_v6 <= r_v5;

            r_b7 <= '{ctl: sq_ctl, byp: byp, bypv: bypv};
            r_dmin7 <= (m23 < m01) ? m23 : m01;
            r_d7 <= dst;
            r_v7 <= sq_val;

            r_b8 <= ws0.b;
            for (int j = 0; j < 4; j++) begin
                r_p8[j] <= 50'($signed(wv[j])) * 50'($signed({1'b0, w[j]}));
            end
            r_w8 <= w;

            r_b9 <= r_b8;
            r_den9 <= 19'(r_w8[0]) + 19'(r_w8[1]) + 19'(r_w8[2]) + 19'(r_w8[3]);
            r_num9 <= 52'(r_p8[0]) + 52'(r_p8[1]) + 52'(r_p8[2]) + 52'(r_p8[3]);

            r_b10 <= r_b9;
            r_neg10 <= r_num9[51];
            r_mag10 <= r_num9[51] ? 52'd0 - r_num9 : r_num9;
            r_den10 <= r_den9;

            r_b11 <= r_b10;
            r_neg11 <= r_neg10;
            r_n11 <= r_mag10 + 52'(r_den10 >> 1);
            r_den11 <= r_den10;

            r_out_valid <= fs.b.ctl.valid && fs.b.ctl.query;
            r_out_value <= res;
            r_out_clamped <= fs.b.ctl.clamped;
        end
    end

    assign o_valid = r_out_valid;
    assign o_value = r_out_value;
    assign o_clamped = r_out_clamped;

endmodule

// File: hw/rtl/idw_chk.sv
`include "assert_macros.svh"

module idw_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata,
    input logic        m_axis_tuser
);

    `CHK_NEXT(a_out_idle_after_reset, i_clk, !i_rst_n, !m_axis_tvalid)
    `CHK_NEXT(a_in_ready_after_reset, i_clk, !i_rst_n, s_axis_tready)
    `CHK_NEXT_RST(a_ready_drop, i_clk, i_rst_n, s_axis_tready && !s_axis_tvalid, s_axis_tready)
    `CHK_NEXT_RST(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))

endmodule

bind inverse_distance_grid_interpolator idw_chk u_chk (.*);

// File: tb/sv/inverse_distance_grid_interpolator_test.sv
`timescale 1ns / 1ps

module inverse_distance_grid_interpolator_test;
    import idw_pkg::*;

    localparam int GRID_N = 64;
    localparam int LATENCY = $clog2(GRID_N) + 93;
    localparam logic [1:0] OP_IGNORED = 2'd3;

    typedef struct {
        logic [31:0] value;
        logic        clamped;
    } t_answer;

    class interp_scoreboard;
        logic [31:0] values [GRID_N*GRID_N];
        logic [31:0] coords [GRID_N];
        logic [30:0] step_size;
        logic [31:0] origin;
        t_answer     answers[$];
        int          failures;
        int          queries;
        int          checked;
        int          clamp_seen;
        int          diagonal_seen;

        function new();
            step_size = STEP_RESET;
            origin = ORIGIN_RESET;
        endfunction

        function void set_reg(logic index, logic [31:0] data);
            if (index == REG_STEP_SIZE) step_size = data[30:0];
            else origin = data;
        endfunction

        function longint sx(logic [31:0] x);
            return longint'(signed'(x));
        endfunction

        function longint cell_of(longint c, ref bit clamped);
            longint stp, diff, q;
            stp = (step_size == 0) ? 1 : longint'(step_size);
            diff = c - sx(origin);
            if (diff >= 0) q = diff / stp;
            else q = -((-diff + stp - 1) / stp);
            if (q < 0) q = 0;
            if (q > GRID_N - 2) begin
                q = GRID_N - 2;
                clamped = 1;
            end
            return q;
        endfunction

        // Queries are kept to cells whose corners lie in the first four or the
        // last two rows and columns, the only ones that are loaded.
        function bit coord_ok(logic [31:0] c);
            bit cl;
            longint q;
            cl = 0;
            q = cell_of(sx(c), cl);
            return (q <= 2) || (q >= GRID_N - 2);
        endfunction

        function longint unsigned abs_sat(longint a, longint b);
            longint d;
            longint unsigned m;
            d = a - b;
            m = (d < 0) ? longint'(-d) : d;
            return (m > 64'h7FFF_FFFF) ? 64'h7FFF_FFFF : m;
        endfunction

        function longint unsigned root_of(longint unsigned x);
            longint unsigned res, b;
            res = 0;
            b = 64'd1 << 62;
            while (b > x) b >>= 2;
            while (b != 0) begin
                if (x >= res + b) begin
                    x -= res + b;
                    res = (res >> 1) + b;
                end else begin
                    res >>= 1;
                end
                b >>= 2;
            end
            return res;
        endfunction

        function longint weighted_mean(longint r, longint r0, longint i0, longint ic);
            longint rw[4], cl[4], val[4], num, q;
            longint unsigned dlen[4], w, dmin, den, mag, dy, dx;
            rw = '{i0, i0, i0 + 1, i0 + 1};
            cl = '{ic, ic + 1, ic + 1, ic};
            for (int k = 0; k < 4; k++) begin
                dy = abs_sat(sx(coords[rw[k]]), r0);
                dx = abs_sat(sx(coords[cl[k]]), r);
                val[k] = sx(values[rw[k] * GRID_N + cl[k]]);
                dlen[k] = root_of(dy * dy + dx * dx);
            end
            for (int k = 0; k < 4; k++)
                if (dlen[k] == 0) return val[k];
            dmin = dlen[0];
            for (int k = 1; k < 4; k++)
                if (dlen[k] < dmin) dmin = dlen[k];
            num = 0;
            den = 0;
            for (int k = 0; k < 4; k++) begin
                w = (dmin << 16) / dlen[k];
                den += w;
                num += val[k] * longint'(w);
            end
            mag = (num < 0) ? longint'(-num) : num;
            q = longint'((mag + den / 2) / den);
            return (num < 0) ? -q : q;
        endfunction

        function void note_item(logic [1:0] op, logic [5:0] row, logic [5:0] col,
                                logic [31:0] data, logic [31:0] r, logic [31:0] r0);
            bit clamped;
            longint i0, ic, res;
            t_answer a;
            if (op == OP_WR_VAL) begin
                values[int'(row) * GRID_N + int'(col)] = data;
            end else if (op == OP_WR_COORD) begin
                coords[col] = data;
            end else if (op == OP_QUERY) begin
                clamped = 0;
                i0 = cell_of(sx(r0), clamped);
                ic = cell_of(sx(r), clamped);
                if (i0 == ic) begin
                    res = sx(values[i0 * GRID_N + ic]);
                    diagonal_seen++;
                end else begin
                    res = weighted_mean(sx(r), sx(r0), i0, ic);
                end
                a.value = res[31:0];
                a.clamped = clamped;
                if (clamped) clamp_seen++;
                answers.push_back(a);
                queries++;
            end
        endfunction

        function void check_result(logic [31:0] value, logic clamped);
            t_answer a;
            if (answers.size() == 0) begin
                $display("%0t: unexpected result value %h flag %b", $time, value, clamped);
                failures++;
                return;
            end
            a = answers.pop_front();
            checked++;
            if (value !== a.value) begin
                $display("%0t: interp_value expected %h actual %h", $time, a.value, value);
                failures++;
            end
            if (clamped !== a.clamped) begin
                $display("%0t: index_clamped expected %b actual %b", $time, a.clamped,
                         clamped);
                failures++;
            end
        endfunction
    endclass

    logic         i_clk;
    logic         i_rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [111:0] s_axis_tdata;
    logic [1:0]   s_axis_tuser;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [31:0]  m_axis_tdata;
    logic         m_axis_tuser;
    logic         i_cfg_we;
    logic         i_cfg_index;
    logic [31:0]  i_cfg_data;

    interp_scoreboard sb;
    int send_idle_pct;
    int recv_idle_pct;
    int hold_cycles;
    logic [30:0] cur_step;
    logic [31:0] cur_origin;

    inverse_distance_grid_interpolator #(.GRID(GRID_N)) uut (.*);

    initial begin
        i_clk = 0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #20ms;
        $display("*** FAILED ***");
        $finish;
    end

    initial begin
        m_axis_tready = 0;
        forever begin
            @(negedge i_clk);
            if (hold_cycles > 0) begin
                m_axis_tready = 0;
                hold_cycles--;
            end else begin
                m_axis_tready = ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && s_axis_tvalid && s_axis_tready)
            sb.note_item(s_axis_tuser, s_axis_tdata[5:0], s_axis_tdata[11:6],
                         s_axis_tdata[43:12], s_axis_tdata[75:44], s_axis_tdata[107:76]);
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tdata, m_axis_tuser);
    end

    function automatic int safe_idx(int n);
        return (n < 4) ? n : GRID_N - 6 + n;
    endfunction

    task automatic send(logic [1:0] op, logic [5:0] row, logic [5:0] col,
                        logic [31:0] data, logic [31:0] r, logic [31:0] r0);
        bit ready_now;
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid = 0;
            @(negedge i_clk);
        end
        s_axis_tuser = op;
        s_axis_tdata = {4'd0, r0, r, data, col, row};
        s_axis_tvalid = 1;
        forever begin
            ready_now = s_axis_tready;
            @(negedge i_clk);
            if (ready_now) break;
        end
        s_axis_tvalid = 0;
    endtask

    task automatic drain();
        int n;
        n = 0;
        while (sb.answers.size() != 0 && n < 200000) begin
            @(negedge i_clk);
            n++;
        end
        repeat (LATENCY + 10) @(negedge i_clk);
    endtask

    task automatic write_reg(logic index, logic [31:0] data);
        i_cfg_we = 1;
        i_cfg_index = index;
        i_cfg_data = data;
        sb.set_reg(index, data);
        @(negedge i_clk);
        i_cfg_we = 0;
    endtask

    task automatic configure(logic [30:0] stp, logic [31:0] org);
        drain();
        write_reg(REG_STEP_SIZE, {1'b0, stp});
        write_reg(REG_ORIGIN, org);
        cur_step = stp;
        cur_origin = org;
        for (int n = 0; n < 6; n++)
            send(OP_WR_COORD, 6'($urandom), 6'(safe_idx(n)),
                 cur_origin + 32'(safe_idx(n)) * {1'b0, cur_step},
                 32'($urandom), 32'($urandom));
    endtask

    function automatic logic [31:0] near_grid();
        logic [31:0] c;
        int k;
        do begin
            k = $urandom_range(3);
            c = cur_origin + 32'((k < 2) ? k : GRID_N - 3 + k) * {1'b0, cur_step}
                + ($urandom % ({1'b0, cur_step} + 32'd1)) - 32'($urandom_range(3));
        end while (!sb.coord_ok(c));
        return c;
    endfunction

    function automatic logic [31:0] wild_coord();
        logic [31:0] c;
        do begin
            c = $urandom;
        end while (!sb.coord_ok(c));
        return c;
    endfunction

    task automatic random_items(int count);
        int pick;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(99);
            if (pick < 8)
                send(OP_WR_VAL, 6'($urandom), 6'($urandom), $urandom, $urandom, $urandom);
            else if (pick < 12)
                send(OP_WR_COORD, 6'($urandom), 6'($urandom), near_grid(), $urandom,
                     $urandom);
            else if (pick < 14)
                send(OP_IGNORED, 6'($urandom), 6'($urandom), $urandom, $urandom, $urandom);
            else if (pick < 80)
                send(OP_QUERY, 6'($urandom), 6'($urandom), $urandom, near_grid(),
                     near_grid());
            else
                send(OP_QUERY, 6'($urandom), 6'($urandom), $urandom, wild_coord(),
                     wild_coord());
        end
    endtask

    initial begin
        sb = new();
        hold_cycles = 0;
        send_idle_pct = 12;
        recv_idle_pct = 60;
        cur_step = STEP_RESET;
        cur_origin = ORIGIN_RESET;
        i_rst_n = 0;
        s_axis_tvalid = 0;
        s_axis_tdata = '0;
        s_axis_tuser = OP_WR_VAL;
        i_cfg_we = 0;
        i_cfg_index = REG_STEP_SIZE;
        i_cfg_data = '0;
        repeat (8) @(negedge i_clk);
        i_rst_n = 1;

        // Load every row and column that a query can reach before any query.
        for (int n = 0; n < 6; n++)
            send(OP_WR_COORD, 6'($urandom), 6'(safe_idx(n)), 32'(safe_idx(n)) << 16,
                 $urandom, $urandom);
        for (int n = 0; n < 36; n++)
            send(OP_WR_VAL, 6'(safe_idx(n / 6)), 6'(safe_idx(n % 6)), $urandom,
                 $urandom, $urandom);

        send(OP_QUERY, 0, 0, 0, 32'h0001_8000, 32'h0001_8000);
        send(OP_QUERY, 0, 0, 0, 32'h0000_4000, 32'h0002_0000);
        send(OP_QUERY, 0, 0, 0, 32'h0002_4000, 32'h0000_C000);
        send(OP_QUERY, 0, 0, 0, 32'h8000_0000, 32'h8000_0000);
        send(OP_QUERY, 0, 0, 0, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send(OP_QUERY, 0, 0, 0, 32'h8000_0000, 32'h7FFF_FFFF);
        send(OP_QUERY, 0, 0, 0, 32'h7FFF_FFFF, 32'h0000_4000);
        send(OP_QUERY, 0, 0, 0, 32'h0040_0000, 32'h003E_0000);
        send(OP_WR_VAL, 6'd63, 6'd63, 32'h8000_0000, 0, 0);
        send(OP_WR_VAL, 6'd0, 6'd0, 32'h7FFF_FFFF, 0, 0);
        send(OP_WR_VAL, 6'd0, 6'd1, 32'h7FFF_FFFF, 0, 0);
        send(OP_QUERY, 0, 0, 0, 32'h0000_4000, 32'h0000_4000);
        send(OP_QUERY, 0, 0, 0, 32'h7FFF_0000, 32'h7FFF_0000);
        send(OP_IGNORED, 6'h3F, 6'h3F, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        // Far corners: extreme coordinates saturate the distance terms.
        send(OP_WR_COORD, 0, 6'd0, 32'h8000_0000, 0, 0);
        send(OP_WR_COORD, 0, 6'd1, 32'h7FFF_FFFF, 0, 0);
        send(OP_QUERY, 0, 0, 0, 32'h0001_8000, 32'h0000_8000);
        send(OP_QUERY, 0, 0, 0, 32'h0000_0001, 32'h0000_FFFF);
        send(OP_WR_COORD, 0, 6'd0, 32'h0000_0000, 0, 0);
        send(OP_WR_COORD, 0, 6'd1, 32'h0001_0000, 0, 0);
        random_items(100);

        configure(31'd1, 32'h8000_0000);
        send_idle_pct = 60;
        recv_idle_pct = 12;
        random_items(120);

        configure(31'h7FFF_FFFF, 32'h7FFF_FFFF);
        random_items(50);

        configure(31'($urandom_range(32'h0000_4000, 32'h0004_0000)), $urandom);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        random_items(60);
        hold_cycles = 400;
        random_items(80);
        drain();

        configure(STEP_RESET, ORIGIN_RESET);
        random_items(60);
        drain();

        $display("Checked %0d of %0d query results, %0d with a clamped index, %0d diagonal.",
                 sb.checked, sb.queries, sb.clamp_seen, sb.diagonal_seen);
        $display("Covered four grid settings, idle and stall mixes and a long output stall.");
        if (sb.failures == 0 && sb.answers.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            if (sb.answers.size() != 0)
                $display("%0t: %0d results never arrived", $time, sb.answers.size());
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

// File: inverse_distance_grid_interpolator.f
+incdir+hw/rtl
hw/rtl/idw_pkg.sv
hw/rtl/idw_ram.sv
hw/rtl/idw_div.sv
hw/rtl/idw_sqrt.sv
hw/rtl/idw_front.sv
hw/rtl/idw_back.sv
hw/rtl/inverse_distance_grid_interpolator.sv
hw/rtl/idw_chk.sv
tb/sv/inverse_distance_grid_interpolator_test.sv
